### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled during arst_n.
// They expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset
`define XMBD_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("xmbd assertion failed");
// Check that a trigger is followed by a condition in the next cycle
`define XMBD_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("xmbd assertion failed");
`else
`define XMBD_ASSERT(name, cond)
`define XMBD_ASSERT_NEXT(name, pre, post)
`endif

`endif

### sv/xmbd_pkg.sv
// ---------------------------------------------------------------------------
// xmbd_pkg
// Types, constants and opcode classification for the MOV byte decoder.
// ---------------------------------------------------------------------------
package xmbd_pkg;

	// Collection phase of the current instruction
	typedef enum logic [2:0] {
		PH_OPCODE = 3'd0,
		PH_MODRM  = 3'd1,
		PH_DLO    = 3'd2,
		PH_DHI    = 3'd3,
		PH_ILO    = 3'd4,
		PH_IHI    = 3'd5
	} phase_t;

	// Recognized instruction form
	typedef enum logic [1:0] {
		FORM_RM_REG  = 2'd0,
		FORM_IMM_REG = 2'd1,
		FORM_IMM_RM  = 2'd2,
		FORM_NONE    = 2'd3
	} form_t;

	// Opcode patterns
	localparam logic [5:0] OP_RM_REG  = 6'b100010;
	localparam logic [3:0] OP_IMM_REG = 4'b1011;
	localparam logic [6:0] OP_IMM_RM  = 7'b1100011;
	localparam logic [2:0] RM_DIRECT  = 3'b110;
	localparam logic [1:0] MOD_MEM0   = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP16 = 2'd2;
	localparam logic [1:0] MOD_REG    = 2'd3;

	// Decoded instruction
	typedef struct packed {
		form_t       form_kind;
		logic        direction;
		logic        wide;
		logic [2:0]  reg_field;
		logic [1:0]  mode_field;
		logic [2:0]  rm_field;
		logic        abs_addr;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic [2:0]  instr_length;
	} result_t;

	// Classify an opcode byte
	function automatic form_t form_of(input logic [7:0] op);
		form_t f;
		if (op[7:2] == OP_RM_REG) begin
			f = FORM_RM_REG;
		end else if (op[7:4] == OP_IMM_REG) begin
			f = FORM_IMM_REG;
		end else if (op[7:1] == OP_IMM_RM) begin
			f = FORM_IMM_RM;
		end else begin
			f = FORM_NONE;
		end
		return f;
	endfunction

	// Displacement byte count selected by a ModRM byte
	function automatic logic [1:0] disp_size(input logic [7:0] modrm);
		logic [1:0] n;
		case (modrm[7:6])
			MOD_MEM0:   n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
			MOD_DISP8:  n = 2'd1;
			MOD_DISP16: n = 2'd2;
			default:    n = 2'd0;
		endcase
		return n;
	endfunction

	// Sign-extend a byte to 16 bits
	function automatic logic [15:0] sext8(input logic [7:0] b);
		return {{8{b[7]}}, b};
	endfunction

endpackage

### sv/x86_mov_byte_decoder.sv
// ---------------------------------------------------------------------------
// x86_mov_byte_decoder
// Byte-serial decoder for the three 8086 MOV encodings.
// ---------------------------------------------------------------------------
// Usage:
//   Code bytes enter on the s_ channel, one request per byte; s_tlast marks
//   the last byte of a stream and returns the decoder to its idle state after
//   that byte, dropping any partial instruction.
//   Each complete instruction leaves as one request on the m_ channel: the
//   form in m_tuser and the decoded fields in m_tdata. Bytes that match no
//   form are consumed without a result.
//   Throughput: one byte per cycle while s_tready is high; each byte is
//   captured directly into the phase and hold registers.
//   The result is registered: it is written to the output register, or to
//   the skid register, when the last byte of an instruction is accepted.
//   Stall: the output register plus one skid register hold results while
//   m_tready is low; s_tready drops only when both are full.
//   Reset: arst_n clears the phase, holds and both output valid flags; the
//   block is ready for an opcode byte right after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module x86_mov_byte_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] code_byte
	input  logic        s_tlast,   // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] direction, [1] wide, [4:2] reg_field, [6:5] mode_field,
	// [9:7] rm_field, [10] abs_addr, [26:11] displacement,
	// [42:27] immediate, [45:43] instr_length, [47:46] zero
	output logic [47:0] m_tdata,
	output logic [1:0]  m_tuser    // [1:0] form_kind
);

	xmbd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  opcode_q, opcode_d;
	logic [7:0]  modrm_q, modrm_d;
	logic [15:0] disp_q, disp_d;
	logic [15:0] imm_q, imm_d;
	logic [2:0]  count_q, count_d;
	logic        done;

	xmbd_pkg::result_t res;
	xmbd_pkg::result_t out_q, skid_q;
	logic        out_v_q, skid_v_q;
	logic        in_fire, out_take;
	xmbd_pkg::form_t in_form, hold_form;
	logic        imm_wide;

	assign s_tready = !skid_v_q;
	assign in_fire  = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign out_take = out_v_q && m_tready;

	assign in_form   = xmbd_pkg::form_of(s_tdata);
	assign hold_form = xmbd_pkg::form_of(opcode_q);
	assign imm_wide  = (hold_form == xmbd_pkg::FORM_IMM_REG) ? opcode_q[3] : opcode_q[0];

	// Advance the collection phase for the incoming byte
	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		modrm_d  = modrm_q;
		disp_d   = disp_q;
		imm_d    = imm_q;
		count_d  = count_q + 3'd1;
		done     = 1'b0;
		case (phase_q)
			xmbd_pkg::PH_MODRM: begin
				modrm_d = s_tdata;
				if (xmbd_pkg::disp_size(s_tdata) != 2'd0) begin
					phase_d = xmbd_pkg::PH_DLO;
				end else if (hold_form == xmbd_pkg::FORM_IMM_RM) begin
					phase_d = xmbd_pkg::PH_ILO;
				end else begin
					done = 1'b1;
				end
			end
			xmbd_pkg::PH_DLO: begin
				if (xmbd_pkg::disp_size(modrm_q) == 2'd1) begin
					disp_d = xmbd_pkg::sext8(s_tdata);
					if (hold_form == xmbd_pkg::FORM_IMM_RM) begin
						phase_d = xmbd_pkg::PH_ILO;
					end else begin
						done = 1'b1;
					end
				end else begin
					disp_d  = {8'd0, s_tdata};
					phase_d = xmbd_pkg::PH_DHI;
				end
			end
			xmbd_pkg::PH_DHI: begin
				disp_d = {s_tdata, disp_q[7:0]};
				if (hold_form == xmbd_pkg::FORM_IMM_RM) begin
					phase_d = xmbd_pkg::PH_ILO;
				end else begin
					done = 1'b1;
				end
			end
			xmbd_pkg::PH_ILO: begin
				if (imm_wide) begin
					imm_d   = {8'd0, s_tdata};
					phase_d = xmbd_pkg::PH_IHI;
				end else begin
					imm_d = xmbd_pkg::sext8(s_tdata);
					done  = 1'b1;
				end
			end
			xmbd_pkg::PH_IHI: begin
				imm_d = {s_tdata, imm_q[7:0]};
				done  = 1'b1;
			end
			default: begin
				count_d = count_q;
				if (in_form != xmbd_pkg::FORM_NONE) begin
					opcode_d = s_tdata;
					modrm_d  = 8'd0;
					disp_d   = 16'd0;
					imm_d    = 16'd0;
					count_d  = 3'd1;
					phase_d  = (in_form == xmbd_pkg::FORM_IMM_REG) ?
						xmbd_pkg::PH_ILO : xmbd_pkg::PH_MODRM;
				end else begin
					phase_d = xmbd_pkg::PH_OPCODE;
				end
			end
		endcase
	end

	// Build the decoded result from the updated holds
	always_comb begin
		res.form_kind    = hold_form;
		res.instr_length = count_d;
		res.immediate    = (hold_form == xmbd_pkg::FORM_RM_REG) ? 16'd0 : imm_d;
		if (hold_form == xmbd_pkg::FORM_IMM_REG) begin
			res.direction    = 1'b1;
			res.wide         = opcode_q[3];
			res.reg_field    = opcode_q[2:0];
			res.mode_field   = xmbd_pkg::MOD_REG;
			res.rm_field     = opcode_q[2:0];
			res.abs_addr     = 1'b0;
			res.displacement = 16'd0;
		end else begin
			res.direction    = (hold_form == xmbd_pkg::FORM_RM_REG) ? opcode_q[1] : 1'b0;
			res.wide         = opcode_q[0];
			res.reg_field    = modrm_d[5:3];
			res.mode_field   = modrm_d[7:6];
			res.rm_field     = modrm_d[2:0];
			res.abs_addr     = (modrm_d[7:6] == xmbd_pkg::MOD_MEM0) &&
				(modrm_d[2:0] == xmbd_pkg::RM_DIRECT);
			res.displacement = disp_d;
		end
	end

	// Update phase and holds; clear on a finished instruction or stream end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= xmbd_pkg::PH_OPCODE;
			opcode_q <= 8'd0;
			modrm_q  <= 8'd0;
			disp_q   <= 16'd0;
			imm_q    <= 16'd0;
			count_q  <= 3'd0;
		end else if (in_fire) begin
			if (done || s_tlast) begin
				phase_q  <= xmbd_pkg::PH_OPCODE;
				opcode_q <= 8'd0;
				modrm_q  <= 8'd0;
				disp_q   <= 16'd0;
				imm_q    <= 16'd0;
				count_q  <= 3'd0;
			end else begin
				phase_q  <= phase_d;
				opcode_q <= opcode_d;
				modrm_q  <= modrm_d;
				disp_q   <= disp_d;
				imm_q    <= imm_d;
				count_q  <= count_d;
			end
		end
	end

	// Output register valid flags with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire && done;
			end
		end else if (in_fire && done) begin
			if (out_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end
	end

	// Output and skid payload
	always_ff @(posedge clk) begin
		if (out_take) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else begin
				out_q <= res;
			end
		end else if (in_fire && done) begin
			if (out_v_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign m_tuser = out_q.form_kind;
	assign m_tdata = {2'b00, out_q.instr_length, out_q.immediate, out_q.displacement,
		out_q.abs_addr, out_q.rm_field, out_q.mode_field, out_q.reg_field,
		out_q.wide, out_q.direction};

	// Skid entry is only used behind a full output register
	`XMBD_ASSERT(a_skid_behind_out, !skid_v_q || out_v_q)
	// Stream end always returns to the opcode phase
	`XMBD_ASSERT_NEXT(a_end_resets, in_fire && s_tlast, phase_q == xmbd_pkg::PH_OPCODE)
	// Every delivered instruction has a legal length
	`XMBD_ASSERT(a_len_legal, !out_v_q || (out_q.instr_length != 3'd0 && out_q.instr_length != 3'd7))

endmodule

### dv/x86_mov_byte_decoder_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// x86_mov_byte_decoder_tb
// Self-checking bench for the byte-serial MOV decoder. A queue of code bytes
// feeds a stream driver, and a built-in decoder model predicts every decoded
// MOV request. A monitor compares each output request field by field.
// The run goes through four throttling phases of sender idles and receiver
// stalls and drains fully between them.
// ---------------------------------------------------------------------------
module x86_mov_byte_decoder_tb;

	// One code byte request on the input stream
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} code_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // [7:0] code_byte
	logic        s_tlast = 1'b0;   // stream_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [0] direction, [1] wide, [4:2] reg_field, [6:5] mode_field,
	// [9:7] rm_field, [10] abs_addr, [26:11] displacement,
	// [42:27] immediate, [45:43] instr_length, [47:46] zero
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;          // [1:0] form_kind

	code_req_t         code_bytes[$];
	xmbd_pkg::result_t expected_movs[$];
	code_req_t         next_req;

	// Decoder model state
	xmbd_pkg::phase_t dec_phase = xmbd_pkg::PH_OPCODE;
	logic [7:0]  dec_opcode = '0;
	logic [7:0]  dec_modrm = '0;
	logic [15:0] dec_disp = '0;
	logic [15:0] dec_imm = '0;
	logic [2:0]  dec_length = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int bytes_accepted = 0;
	int stream_ends = 0;
	int form_seen[4] = '{default: 0};

	x86_mov_byte_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Classify an opcode byte into one of the MOV forms
	function automatic xmbd_pkg::form_t opcode_form(input logic [7:0] op);
		if (op[7:2] == xmbd_pkg::OP_RM_REG)
			return xmbd_pkg::FORM_RM_REG;
		if (op[7:4] == xmbd_pkg::OP_IMM_REG)
			return xmbd_pkg::FORM_IMM_REG;
		if (op[7:1] == xmbd_pkg::OP_IMM_RM)
			return xmbd_pkg::FORM_IMM_RM;
		return xmbd_pkg::FORM_NONE;
	endfunction

	// Number of displacement bytes that follow a ModRM byte
	function automatic int disp_len(input logic [7:0] modrm);
		case (modrm[7:6])
			xmbd_pkg::MOD_DISP8:  return 1;
			xmbd_pkg::MOD_DISP16: return 2;
			xmbd_pkg::MOD_MEM0:   return (modrm[2:0] == xmbd_pkg::RM_DIRECT) ? 2 : 0;
			default:              return 0;
		endcase
	endfunction

	function automatic void clear_decoder();
		dec_phase = xmbd_pkg::PH_OPCODE;
		dec_opcode = '0;
		dec_modrm = '0;
		dec_disp = '0;
		dec_imm = '0;
		dec_length = '0;
	endfunction

	// Advance the decoder model by one accepted byte; queue a finished MOV
	function automatic void decode_step(input logic [7:0] b, input logic last);
		xmbd_pkg::form_t   f;
		logic              done;
		xmbd_pkg::result_t r;
		f = opcode_form(dec_opcode);
		done = 1'b0;
		r = '0;
		case (dec_phase)
			xmbd_pkg::PH_MODRM: begin
				dec_modrm = b;
				dec_length = dec_length + 3'd1;
				if (disp_len(b) != 0)
					dec_phase = xmbd_pkg::PH_DLO;
				else if (f == xmbd_pkg::FORM_IMM_RM)
					dec_phase = xmbd_pkg::PH_ILO;
				else
					done = 1'b1;
			end
			xmbd_pkg::PH_DLO: begin
				dec_length = dec_length + 3'd1;
				if (disp_len(dec_modrm) == 1) begin
					dec_disp = {{8{b[7]}}, b};
					if (f == xmbd_pkg::FORM_IMM_RM)
						dec_phase = xmbd_pkg::PH_ILO;
					else
						done = 1'b1;
				end else begin
					dec_disp = {8'h00, b};
					dec_phase = xmbd_pkg::PH_DHI;
				end
			end
			xmbd_pkg::PH_DHI: begin
				dec_length = dec_length + 3'd1;
				dec_disp[15:8] = b;
				if (f == xmbd_pkg::FORM_IMM_RM)
					dec_phase = xmbd_pkg::PH_ILO;
				else
					done = 1'b1;
			end
			xmbd_pkg::PH_ILO: begin
				dec_length = dec_length + 3'd1;
				if ((f == xmbd_pkg::FORM_IMM_REG) ? dec_opcode[3] : dec_opcode[0]) begin
					dec_imm = {8'h00, b};
					dec_phase = xmbd_pkg::PH_IHI;
				end else begin
					dec_imm = {{8{b[7]}}, b};
					done = 1'b1;
				end
			end
			xmbd_pkg::PH_IHI: begin
				dec_length = dec_length + 3'd1;
				dec_imm[15:8] = b;
				done = 1'b1;
			end
			default: begin
				// Opcode phase: latch a recognized opcode, skip anything else
				f = opcode_form(b);
				if (f != xmbd_pkg::FORM_NONE) begin
					dec_opcode = b;
					dec_modrm = '0;
					dec_disp = '0;
					dec_imm = '0;
					dec_length = 3'd1;
					dec_phase = (f == xmbd_pkg::FORM_IMM_REG) ?
						xmbd_pkg::PH_ILO : xmbd_pkg::PH_MODRM;
				end else begin
					dec_phase = xmbd_pkg::PH_OPCODE;
				end
			end
		endcase

		if (done) begin
			r.form_kind = f;
			if (f == xmbd_pkg::FORM_IMM_REG) begin
				// Register is the destination; no ModRM byte
				r.direction = 1'b1;
				r.wide = dec_opcode[3];
				r.reg_field = dec_opcode[2:0];
				r.mode_field = xmbd_pkg::MOD_REG;
				r.rm_field = dec_opcode[2:0];
			end else begin
				r.direction = (f == xmbd_pkg::FORM_RM_REG) ? dec_opcode[1] : 1'b0;
				r.wide = dec_opcode[0];
				r.reg_field = dec_modrm[5:3];
				r.mode_field = dec_modrm[7:6];
				r.rm_field = dec_modrm[2:0];
				r.abs_addr = (dec_modrm[7:6] == xmbd_pkg::MOD_MEM0) &&
					(dec_modrm[2:0] == xmbd_pkg::RM_DIRECT);
				r.displacement = dec_disp;
			end
			r.immediate = (f == xmbd_pkg::FORM_RM_REG) ? 16'h0000 : dec_imm;
			r.instr_length = dec_length;
			expected_movs.push_back(r);
			clear_decoder();
		end
		if (last)
			clear_decoder();
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// Compare one output request against the oldest predicted MOV
	task automatic check_decode();
		xmbd_pkg::result_t want;
		if (expected_movs.size() == 0) begin
			report_mismatch($sformatf("result with no instruction pending: tdata 0x%0h",
				m_tdata));
		end else begin
			want = expected_movs.pop_front();
			compare_field("form_kind", 16'(m_tuser), 16'(want.form_kind));
			compare_field("direction", 16'(m_tdata[0]), 16'(want.direction));
			compare_field("wide", 16'(m_tdata[1]), 16'(want.wide));
			compare_field("reg_field", 16'(m_tdata[4:2]), 16'(want.reg_field));
			compare_field("mode_field", 16'(m_tdata[6:5]), 16'(want.mode_field));
			compare_field("rm_field", 16'(m_tdata[9:7]), 16'(want.rm_field));
			compare_field("abs_addr", 16'(m_tdata[10]), 16'(want.abs_addr));
			compare_field("displacement", m_tdata[26:11], want.displacement);
			compare_field("immediate", m_tdata[42:27], want.immediate);
			compare_field("instr_length", 16'(m_tdata[45:43]), 16'(want.instr_length));
			form_seen[int'(want.form_kind)]++;
		end
	endtask

	task automatic push_byte(input logic [7:0] code, input logic last);
		code_bytes.push_back('{code: code, last: last});
	endtask

	// Queue mostly well-formed MOVs with random content, plus noise bytes,
	// stream ends and instructions cut short by a stream end
	task automatic queue_random_stream(input int n_bytes);
		int              total;
		int              n;
		int              cut;
		logic [7:0]      seq[6];
		xmbd_pkg::form_t f;
		logic            w;
		total = 0;
		while (total < n_bytes) begin
			if ($urandom_range(0, 99) < 12) begin
				push_byte(8'($urandom), $urandom_range(0, 99) < 3);
				total++;
			end else begin
				f = xmbd_pkg::form_t'($urandom_range(0, 2));
				case (f)
					xmbd_pkg::FORM_RM_REG:  seq[0] = {xmbd_pkg::OP_RM_REG, 2'($urandom)};
					xmbd_pkg::FORM_IMM_REG: seq[0] = {xmbd_pkg::OP_IMM_REG, 4'($urandom)};
					default:                seq[0] = {xmbd_pkg::OP_IMM_RM, 1'($urandom)};
				endcase
				n = 1;
				if (f == xmbd_pkg::FORM_IMM_REG) begin
					w = seq[0][3];
				end else begin
					w = seq[0][0];
					seq[1] = 8'($urandom);
					n = 2;
					repeat (disp_len(seq[1])) begin
						seq[n] = 8'($urandom);
						n++;
					end
				end
				if (f != xmbd_pkg::FORM_RM_REG) begin
					repeat (w ? 2 : 1) begin
						seq[n] = 8'($urandom);
						n++;
					end
				end
				cut = ($urandom_range(0, 99) < 6) ? $urandom_range(0, n - 2) : n - 1;
				for (int i = 0; i <= cut; i++)
					push_byte(seq[i], (i < cut) ? 1'b0 :
						((cut < n - 1) || ($urandom_range(0, 99) < 4)));
				total += cut + 1;
			end
		end
	endtask

	// Hold the sender until every queued byte is taken and every MOV is back
	task automatic wait_drained();
		while (code_bytes.size() != 0 || s_tvalid || expected_movs.size() != 0)
			@(negedge clk);
	endtask

	// Input driver: hold a request until taken, then offer the next or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_step(s_tdata, s_tlast);
				bytes_accepted++;
				if (s_tlast)
					stream_ends++;
			end
			if (!s_tvalid || s_tready) begin
				if (code_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = code_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_req.code;
					s_tlast <= next_req.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check each taken request, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_decode();
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		clear_decoder();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: unrecognized bytes, each form, both operand sizes,
		// direct address, sign extension, nonzero reg bits in the
		// immediate-to-reg/mem form and stream ends mid-instruction
		push_byte(8'h00, 1'b0);
		push_byte({xmbd_pkg::OP_RM_REG, 2'b01}, 1'b0);
		push_byte({xmbd_pkg::MOD_REG, 3'd3, 3'd0}, 1'b0);
		push_byte({xmbd_pkg::OP_RM_REG, 2'b11}, 1'b0);
		push_byte({xmbd_pkg::MOD_MEM0, 3'd0, xmbd_pkg::RM_DIRECT}, 1'b0);
		push_byte(8'h34, 1'b0);
		push_byte(8'h12, 1'b0);
		push_byte({xmbd_pkg::OP_IMM_REG, 1'b1, 3'd7}, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte({xmbd_pkg::OP_IMM_REG, 1'b0, 3'd0}, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte({xmbd_pkg::OP_IMM_RM, 1'b1}, 1'b0);
		push_byte({xmbd_pkg::MOD_DISP16, 3'd0, 3'd4}, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte({xmbd_pkg::OP_IMM_RM, 1'b0}, 1'b0);
		push_byte({xmbd_pkg::MOD_DISP8, 3'd7, 3'd0}, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte({xmbd_pkg::OP_RM_REG, 2'b00}, 1'b0);
		push_byte({xmbd_pkg::MOD_DISP8, 3'd0, xmbd_pkg::RM_DIRECT}, 1'b1);
		push_byte(8'hFF, 1'b1);

		// Free-running phase, then sender idles, receiver stalls, both light
		queue_random_stream(290);
		wait_drained();
		send_idle_pct = 63;
		queue_random_stream(290);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 63;
		queue_random_stream(290);
		wait_drained();
		send_idle_pct = 7;
		recv_stall_pct = 7;
		queue_random_stream(290);
		wait_drained();

		// Let any stray output request show up
		repeat (10) @(negedge clk);
		if (expected_movs.size() != 0)
			report_mismatch($sformatf("%0d decoded MOVs never arrived", expected_movs.size()));

		$display("Run took %0d code bytes with %0d stream ends over four throttle phases",
			bytes_accepted, stream_ends);
		$display("Checked MOVs: %0d reg/mem-reg, %0d imm-reg, %0d imm-reg/mem; %0d mismatches",
			form_seen[xmbd_pkg::FORM_RM_REG], form_seen[xmbd_pkg::FORM_IMM_REG],
			form_seen[xmbd_pkg::FORM_IMM_RM], mismatch_count);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Timeout with %0d bytes queued and %0d MOVs pending",
			code_bytes.size(), expected_movs.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/xmbd_pkg.sv
sv/x86_mov_byte_decoder.sv
dv/x86_mov_byte_decoder_tb.sv
